// ===== rtl/rldc_pkg.sv =====
package rldc_pkg;

  // Width of a block's byte target: up to 255 elements of 4 bytes.
  localparam int TB_W      = 10;
  // Lanes of the chunk and output word.
  localparam int CHUNK_MAX = 8;

  typedef enum logic [1:0] {
    WK_NONE,
    WK_ONE,
    WK_RUN,
    WK_MATCH
  } work_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic push_in;
    logic push_val;
    logic mread;
    logic push_hist;
    logic settle;
  } cmd_t;

  typedef struct packed {
    work_e work;
    logic  push_ok;
    logic  cnt_last;
    logic  fin_wait;
  } sts_t;

endpackage

// ===== rtl/rldc_if.sv =====
interface rldc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] element_count;

  modport source (output valid, output payload_byte, output first_byte, output last_byte,
                  output element_count, input ready);
  modport sink (input valid, input payload_byte, input first_byte, input last_byte,
                input element_count, output ready);
endinterface

interface rldc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic [2:0]  status;
  logic        block_end;

  modport source (output valid, output chunk_data, output chunk_bytes, output status,
                  output block_end, input ready);
  modport sink (input valid, input chunk_data, input chunk_bytes, input status,
                input block_end, output ready);
endinterface

// ===== rtl/rle_lz_block_decompressor_top.sv =====
// Channel  Dir  Beat contents
// in_i     in   payload_byte, first_byte, last_byte, element_count
// out_o    out  chunk_data, chunk_bytes, status, block_end
// cfg      in   cfg_we_i / cfg_wdata_i = element_width_sel
//
// Every input beat passes through take, decode and settle. A literal or
// identity byte adds a push step; a run adds a push per output byte; a match
// adds a registered history memory read and a push per output byte.
// Reset clears all control state; the history memory is not cleared.
// A full chunk that cannot leave because out_o is stalled holds the engine.
module rle_lz_block_decompressor_top
  import rldc_pkg::*;
#(
  parameter int MAX_ELEMENTS  = 128,
  parameter int HISTORY_BYTES = 512,
  parameter int CHUNK_BYTES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  rldc_in_if.sink    in_i,
  rldc_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one beat in flight, steps the datapath through its copy loops.
  rldc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // Parser, chunk packer, history memory and output register.
  rldc_dp #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .HISTORY_BYTES (HISTORY_BYTES),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .payload_byte_i  (in_i.payload_byte),
    .first_byte_i    (in_i.first_byte),
    .last_byte_i     (in_i.last_byte),
    .element_count_i (in_i.element_count),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .chunk_data_o    (out_o.chunk_data),
    .chunk_bytes_o   (out_o.chunk_bytes),
    .status_o        (out_o.status),
    .block_end_o     (out_o.block_end)
  );

endmodule

// ===== rtl/rldc_ctrl.sv =====
module rldc_ctrl
  import rldc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IN  = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_ONE = 3'd2;
  localparam logic [2:0] S_RUN = 3'd3;
  localparam logic [2:0] S_MRD = 3'd4;
  localparam logic [2:0] S_MWR = 3'd5;
  localparam logic [2:0] S_END = 3'd6;

  logic [2:0] st_q, st_d;

  always_comb begin
    st_d       = st_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      S_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        case (sts_i.work)
          WK_ONE:   st_d = S_ONE;
          WK_RUN:   st_d = S_RUN;
          WK_MATCH: st_d = S_MRD;
          default:  st_d = S_END;
        endcase
      end
      S_ONE: begin
        if (sts_i.push_ok) begin
          cmd_o.push_in = 1'b1;
          st_d          = S_END;
        end
      end
      S_RUN: begin
        if (sts_i.push_ok) begin
          cmd_o.push_val = 1'b1;
          if (sts_i.cnt_last) st_d = S_END;
        end
      end
      S_MRD: begin
        cmd_o.mread = 1'b1;
        st_d        = S_MWR;
      end
      S_MWR: begin
        if (sts_i.push_ok) begin
          cmd_o.push_hist = 1'b1;
          st_d            = sts_i.cnt_last ? S_END : S_MRD;
        end
      end
      S_END: begin
        cmd_o.settle = 1'b1;
        if (!sts_i.fin_wait) st_d = S_IN;
      end
      default: st_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IN;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ===== rtl/rldc_dp.sv =====
module rldc_dp
  import rldc_pkg::*;
#(
  parameter int MAX_ELEMENTS  = 128,
  parameter int HISTORY_BYTES = 512,
  parameter int CHUNK_BYTES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  element_count_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [63:0] chunk_data_o,
  output logic [3:0]  chunk_bytes_o,
  output logic [2:0]  status_o,
  output logic        block_end_o
);

  localparam int PW = $clog2(HISTORY_BYTES + 1);
  localparam int AW = $clog2(HISTORY_BYTES);
  localparam int CW = ((PW > TB_W) ? PW : TB_W) + 1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_COUNT_HI = 3'd2;
  localparam logic [2:0] PH_VALUE   = 3'd3;
  localparam logic [2:0] PH_LIT     = 3'd4;
  localparam logic [2:0] PH_OFF_LO  = 3'd5;
  localparam logic [2:0] PH_OFF_HI  = 3'd6;
  localparam logic [2:0] PH_HALT    = 3'd7;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_CODEC     = 3'd1;
  localparam logic [2:0] STS_TRUNC     = 3'd2;
  localparam logic [2:0] STS_OFFSET    = 3'd3;
  localparam logic [2:0] STS_OVERFLOW  = 3'd4;
  localparam logic [2:0] STS_SHORT     = 3'd5;
  localparam logic [2:0] STS_EMPTY     = 3'd6;

  localparam logic [1:0] CODEC_COPY = 2'd0;
  localparam logic [1:0] CODEC_RLE  = 2'd1;
  localparam logic [1:0] CODEC_BAD  = 2'd3;

  logic [7:0] mem_q [HISTORY_BYTES];

  logic                       sel_q;
  logic [7:0]                 b_q, cnt_in_q;
  logic                       first_q, last_q;
  logic                       eb4_q, eb4_d;
  logic [TB_W-1:0]            tgt_q, tgt_d;
  logic [1:0]                 codec_q, codec_d;
  logic [2:0]                 ph_q, ph_d;
  logic [15:0]                run_q, run_d;
  logic [3:0][7:0]            val_q, val_d;
  logic [1:0]                 bidx_q, bidx_d;
  logic [7:0]                 offlo_q, offlo_d;
  logic [PW-1:0]              off_q, off_d;
  logic [CHUNK_MAX-1:0][7:0]  chunk_q, chunk_d;
  logic [3:0]                 fill_q, fill_d;
  logic [2:0]                 err_q, err_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [TB_W-1:0]            cnt_q, cnt_d;
  logic [7:0]                 rdata_q;
  logic                       ovalid_q, ovalid_d;
  logic [63:0]                odata_q, odata_d;
  logic [3:0]                 obytes_q, obytes_d;
  logic [2:0]                 ostat_q, ostat_d;
  logic                       oend_q, oend_d;

  logic [TB_W-1:0] tb_open;
  logic [CW-1:0]   pos_c, tgt_c, avail, avail_el;
  logic [15:0]     off16, nel;
  logic            elem_done, out_free, fin_need, chunk_full, push_en;
  logic [7:0]      pb;
  logic [2:0]      fin_stat;
  work_e           work;

  assign pos_c      = CW'(pos_q);
  assign tgt_c      = CW'(tgt_q);
  assign avail      = tgt_c - pos_c;
  assign avail_el   = eb4_q ? (avail >> 2) : (avail >> 1);
  assign nel        = (run_q < 16'(avail_el)) ? run_q : 16'(avail_el);
  assign off16      = {b_q, offlo_q};
  assign elem_done  = eb4_q ? (bidx_q == 2'd3) : (bidx_q == 2'd1);
  assign tb_open    = sel_q ? {cnt_in_q, 2'b00} : {1'b0, cnt_in_q, 1'b0};
  assign out_free   = !ovalid_q || out_ready_i;
  assign fin_need   = last_q && (ph_q != PH_IDLE);
  assign chunk_full = (fill_q == 4'(CHUNK_BYTES));
  assign push_en    = cmd_i.push_in || cmd_i.push_val || cmd_i.push_hist;

  always_comb begin
    if (cmd_i.push_in)       pb = b_q;
    else if (cmd_i.push_val) pb = val_q[bidx_q];
    else                     pb = rdata_q;
  end

  always_comb begin
    if (err_q != STS_OK)                                 fin_stat = err_q;
    else if (pos_c >= tgt_c)                             fin_stat = STS_OK;
    else if (codec_q == CODEC_COPY || ph_q == PH_VALUE || ph_q == PH_LIT ||
             ph_q == PH_OFF_LO || ph_q == PH_OFF_HI)     fin_stat = STS_TRUNC;
    else                                                 fin_stat = STS_SHORT;
  end

  always_comb begin
    eb4_d    = eb4_q;
    tgt_d    = tgt_q;
    codec_d  = codec_q;
    ph_d     = ph_q;
    run_d    = run_q;
    val_d    = val_q;
    bidx_d   = bidx_q;
    offlo_d  = offlo_q;
    off_d    = off_q;
    chunk_d  = chunk_q;
    fill_d   = fill_q;
    err_d    = err_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    obytes_d = obytes_q;
    ostat_d  = ostat_q;
    oend_d   = oend_q;
    work     = WK_NONE;

    if (cmd_i.decode) begin
      if (first_q) begin
        pos_d   = '0;
        chunk_d = '0;
        fill_d  = '0;
        err_d   = STS_OK;
        run_d   = '0;
        val_d   = '0;
        bidx_d  = '0;
        offlo_d = '0;
        eb4_d   = sel_q;
        tgt_d   = tb_open;
        codec_d = (b_q <= 8'd2) ? b_q[1:0] : CODEC_BAD;
        ph_d    = PH_BODY;
        if (cnt_in_q == 8'd0) begin
          err_d = STS_EMPTY;
          ph_d  = PH_HALT;
        end else if (32'(cnt_in_q) > MAX_ELEMENTS || 32'(tb_open) > HISTORY_BYTES) begin
          err_d = STS_OVERFLOW;
          ph_d  = PH_HALT;
        end else if (b_q > 8'd2) begin
          err_d = STS_CODEC;
          ph_d  = PH_HALT;
        end
      end else begin
        unique case (ph_q)
          PH_BODY: begin
            if (codec_q == CODEC_COPY) begin
              work = WK_ONE;
            end else if (codec_q == CODEC_RLE) begin
              run_d = {8'd0, b_q};
              ph_d  = PH_COUNT_HI;
            end else if (b_q[7]) begin
              run_d = {9'd0, b_q[6:0]};
              ph_d  = PH_OFF_LO;
            end else if (pos_c + CW'(b_q) > tgt_c) begin
              err_d   = STS_OVERFLOW;
              ph_d    = PH_HALT;
              chunk_d = '0;
              fill_d  = '0;
            end else if (b_q != 8'd0) begin
              run_d = {8'd0, b_q};
              ph_d  = PH_LIT;
            end
          end
          PH_COUNT_HI: begin
            run_d  = {b_q, run_q[7:0]};
            bidx_d = '0;
            val_d  = '0;
            ph_d   = PH_VALUE;
          end
          PH_VALUE: begin
            val_d[bidx_q] = b_q;
            if (elem_done) begin
              bidx_d = '0;
              cnt_d  = eb4_q ? TB_W'({nel, 2'b00}) : TB_W'({nel, 1'b0});
              ph_d   = PH_BODY;
              if (nel != 16'd0) work = WK_RUN;
            end else begin
              bidx_d = bidx_q + 2'd1;
            end
          end
          PH_LIT: begin
            work  = WK_ONE;
            run_d = run_q - 16'd1;
            if (run_q == 16'd1) ph_d = PH_BODY;
          end
          PH_OFF_LO: begin
            offlo_d = b_q;
            ph_d    = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            if (off16 == 16'd0 || off16 > 16'(pos_q)) begin
              err_d   = STS_OFFSET;
              ph_d    = PH_HALT;
              chunk_d = '0;
              fill_d  = '0;
            end else if (pos_c + CW'(run_q[6:0]) > tgt_c) begin
              err_d   = STS_OVERFLOW;
              ph_d    = PH_HALT;
              chunk_d = '0;
              fill_d  = '0;
            end else begin
              cnt_d = TB_W'(run_q[6:0]);
              off_d = PW'(off16);
              ph_d  = PH_BODY;
              if (run_q[6:0] != 7'd0) work = WK_MATCH;
            end
          end
          default: ;
        endcase
      end
    end

    // One byte into the chunk; a full chunk leaves first.
    if (push_en) begin
      if (chunk_full) begin
        ovalid_d = 1'b1;
        odata_d  = chunk_q;
        obytes_d = fill_q;
        ostat_d  = STS_OK;
        oend_d   = 1'b0;
        chunk_d  = '0;
        chunk_d[0] = pb;
        fill_d   = 4'd1;
      end else begin
        chunk_d[fill_q[2:0]] = pb;
        fill_d = fill_q + 4'd1;
      end
      pos_d = pos_q + PW'(1);
      cnt_d = cnt_q - TB_W'(1);
      if (cmd_i.push_val) bidx_d = elem_done ? 2'd0 : bidx_q + 2'd1;
    end

    if (cmd_i.settle) begin
      if (fin_need) begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = chunk_q;
          obytes_d = fill_q;
          ostat_d  = fin_stat;
          oend_d   = 1'b1;
          chunk_d  = '0;
          fill_d   = '0;
          ph_d     = PH_IDLE;
        end
      end else if (err_q == STS_OK && ph_q != PH_IDLE && ph_q != PH_HALT &&
                   pos_c >= tgt_c) begin
        ph_d = PH_HALT;
      end
    end
  end

  assign sts_o.work     = work;
  assign sts_o.push_ok  = !chunk_full || out_free;
  assign sts_o.cnt_last = (cnt_q == TB_W'(1));
  assign sts_o.fin_wait = fin_need && !out_free;

  assign out_valid_o   = ovalid_q;
  assign chunk_data_o  = odata_q;
  assign chunk_bytes_o = obytes_q;
  assign status_o      = ostat_q;
  assign block_end_o   = oend_q;

  always_ff @(posedge clk_i) begin
    if (push_en) mem_q[pos_q[AW-1:0]] <= pb;
    if (cmd_i.mread) rdata_q <= mem_q[AW'(pos_q - off_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q      <= payload_byte_i;
      first_q  <= first_byte_i;
      last_q   <= last_byte_i;
      cnt_in_q <= element_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= 1'b0;
      eb4_q    <= 1'b0;
      tgt_q    <= '0;
      codec_q  <= CODEC_COPY;
      ph_q     <= PH_IDLE;
      run_q    <= '0;
      val_q    <= '0;
      bidx_q   <= '0;
      offlo_q  <= '0;
      off_q    <= '0;
      chunk_q  <= '0;
      fill_q   <= '0;
      err_q    <= STS_OK;
      pos_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      obytes_q <= '0;
      ostat_q  <= STS_OK;
      oend_q   <= 1'b0;
    end else begin
      if (cfg_we_i) sel_q <= cfg_wdata_i;
      eb4_q    <= eb4_d;
      tgt_q    <= tgt_d;
      codec_q  <= codec_d;
      ph_q     <= ph_d;
      run_q    <= run_d;
      val_q    <= val_d;
      bidx_q   <= bidx_d;
      offlo_q  <= offlo_d;
      off_q    <= off_d;
      chunk_q  <= chunk_d;
      fill_q   <= fill_d;
      err_q    <= err_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
      obytes_q <= obytes_d;
      ostat_q  <= ostat_d;
      oend_q   <= oend_d;
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == STS_OK && ph_q != PH_IDLE) |-> (pos_c <= tgt_c))
    else $error("output position ran past block target");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 4'(CHUNK_BYTES))
    else $error("chunk fill beyond chunk size");

  a_flush_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && chunk_full) |-> out_free)
    else $error("chunk flushed into busy output register");
`endif

endmodule
